// ===== sv/cle_pkg.sv =====
// -----------------------------------------------------------------------------
// cle_pkg
// Shared sizes, character codes, result kinds and controller types for the
// console line editor.
// -----------------------------------------------------------------------------
package cle_pkg;

   // line store sizing
   localparam int LINE_LEN = 16;
   localparam int ADDR_W   = $clog2(LINE_LEN);
   localparam int FILL_W   = $clog2(LINE_LEN + 1);

   // field widths
   localparam int BYTE_W = 8;
   localparam int KIND_W = 2;
   localparam int LEN_W  = 4;
   localparam int COPY_W = 5;
   localparam int CNT_W  = (FILL_W > COPY_W) ? FILL_W : COPY_W;

   // register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_ECHO = 1'b0;
   localparam logic REG_COPY = 1'b1;
   localparam logic [COPY_W-1:0] COPY_RESET = 5'd16;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_ECHO    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LINE    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_END     = 2'd2;
   localparam logic [KIND_W-1:0] KIND_OVERRUN = 2'd3;

   // character codes
   localparam logic [BYTE_W-1:0] CH_CR          = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF          = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_BS          = 8'h08;
   localparam logic [BYTE_W-1:0] CH_DEL         = 8'h7F;
   localparam logic [BYTE_W-1:0] CH_FIRST_PRINT = 8'h20;
   localparam logic [BYTE_W-1:0] CH_LAST_PRINT  = 8'h7E;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ONE,
      ST_START,
      ST_ERD,
      ST_EEMIT,
      ST_CR,
      ST_LF,
      ST_CRD,
      ST_CEMIT,
      ST_END
   } state_type;

   // source of the next result beat
   typedef enum logic [2:0] {
      SEL_ONE,
      SEL_ECHO_RAM,
      SEL_CR,
      SEL_LF,
      SEL_LINE_RAM,
      SEL_END
   } out_sel_type;

   typedef struct packed {
      logic        accept;
      logic        idx_clr;
      logic        idx_inc;
      logic        out_load;
      out_sel_type out_sel;
   } cmd_type;

   typedef struct packed {
      logic is_cr;
      logic has_result;
      logic echo_line;
      logic copy_any;
      logic echo_done;
      logic copy_done;
      logic slot_free;
   } status_type;

endpackage

// ===== sv/cle_ram.sv =====
// -----------------------------------------------------------------------------
// cle_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module cle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/cle_ctrl.sv =====
// -----------------------------------------------------------------------------
// cle_ctrl
// Sequencer for the line editor: takes one byte, then walks the result
// beats it causes, one beat per free output slot.
// -----------------------------------------------------------------------------
module cle_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  cle_pkg::status_type status,
   output cle_pkg::cmd_type    cmd
);

   import cle_pkg::*;

   state_type state_ff;
   state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd.accept   = 1'b0;
      cmd.idx_clr  = 1'b0;
      cmd.idx_inc  = 1'b0;
      cmd.out_load = 1'b0;
      cmd.out_sel  = SEL_ONE;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept  = 1'b1;
               cmd.idx_clr = 1'b1;
               if (status.is_cr) begin
                  state_in = ST_START;
               end else if (status.has_result) begin
                  state_in = ST_ONE;
               end
            end
         end
         ST_ONE: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_ONE;
               state_in     = ST_IDLE;
            end
         end
         ST_START: begin
            state_in = status.echo_line ? ST_ERD : ST_CR;
         end
         // wait state while the registered store read settles
         ST_ERD: begin
            state_in = ST_EEMIT;
         end
         ST_EEMIT: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_ECHO_RAM;
               if (status.echo_done) begin
                  cmd.idx_clr = 1'b1;
                  state_in    = ST_CR;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_ERD;
               end
            end
         end
         ST_CR: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_CR;
               state_in     = ST_LF;
            end
         end
         ST_LF: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_LF;
               state_in     = status.copy_any ? ST_CRD : ST_END;
            end
         end
         ST_CRD: begin
            state_in = ST_CEMIT;
         end
         ST_CEMIT: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_LINE_RAM;
               if (status.copy_done) begin
                  state_in = ST_END;
               end else begin
                  cmd.idx_inc = 1'b1;
                  state_in    = ST_CRD;
               end
            end
         end
         ST_END: begin
            if (status.slot_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = SEL_END;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/cle_dpath.sv =====
// -----------------------------------------------------------------------------
// cle_dpath
// Line editor datapath: byte classification, fill count, line store,
// replay index and the result output register.
// -----------------------------------------------------------------------------
module cle_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  cle_pkg::cmd_type                cmd,
   output cle_pkg::status_type             status,
   input  logic [cle_pkg::BYTE_W-1:0]      req_rx_byte,
   input  logic                            echo_at_line_end,
   input  logic [cle_pkg::COPY_W-1:0]      copy_limit,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cle_pkg::KIND_W-1:0]      rsp_result_kind,
   output logic [cle_pkg::BYTE_W-1:0]      rsp_out_byte,
   output logic [cle_pkg::LEN_W-1:0]       rsp_line_length,
   output logic                            rsp_run_last
);

   import cle_pkg::*;

   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   logic [FILL_W-1:0] len_ff;
   logic [FILL_W-1:0] ncopy_ff;
   logic [ADDR_W-1:0] idx_ff;
   logic [KIND_W-1:0] one_kind_ff;
   logic [BYTE_W-1:0] one_byte_ff;

   logic              rsp_valid_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [BYTE_W-1:0] byte_ff;
   logic [LEN_W-1:0]  length_ff;
   logic              last_ff;

   logic              is_cr;
   logic              is_print;
   logic              is_bs;
   logic              full;
   logic              empty;
   logic              store_we;
   logic [FILL_W-1:0] len_in;
   logic [CNT_W-1:0]  ncopy_in;
   logic [FILL_W-1:0] idx_next;
   logic [BYTE_W-1:0] ram_rdata;

   // classify the incoming byte
   always_comb begin
      is_cr    = (req_rx_byte == CH_CR);
      is_print = req_rx_byte inside {[CH_FIRST_PRINT:CH_LAST_PRINT]};
      is_bs    = req_rx_byte inside {CH_BS, CH_DEL};
      full     = (fill_ff >= FILL_W'(LINE_LEN));
      empty    = (fill_ff == '0);
      store_we = cmd.accept && !is_cr && !full && is_print;
   end

   // line length at CR and bytes to copy out
   always_comb begin
      len_in   = full ? FILL_W'(LINE_LEN - 1) : fill_ff;
      ncopy_in = (CNT_W'(copy_limit) < CNT_W'(len_in)) ? CNT_W'(copy_limit)
                                                       : CNT_W'(len_in);
   end

   // fill count update
   always_comb begin
      fill_in = fill_ff;
      if (cmd.accept) begin
         if (is_cr || full) begin
            fill_in = '0;
         end else if (is_print) begin
            fill_in = fill_ff + 1'b1;
         end else if (is_bs && !empty) begin
            fill_in = fill_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // per-item captures
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         one_kind_ff <= full ? KIND_OVERRUN : KIND_ECHO;
         one_byte_ff <= full ? '0 : req_rx_byte;
         if (is_cr) begin
            len_ff   <= len_in;
            ncopy_ff <= FILL_W'(ncopy_in);
         end
      end
   end

   // replay index
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else if (cmd.idx_clr) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + 1'b1;
      end
   end

   assign idx_next = FILL_W'(idx_ff) + 1'b1;

   // line store
   cle_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (LINE_LEN)
   ) u_store (
      .clock (clock),
      .we    (store_we),
      .waddr (fill_ff[ADDR_W-1:0]),
      .wdata (req_rx_byte),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         length_ff <= '0;
         last_ff   <= 1'b0;
         case (cmd.out_sel)
            SEL_ONE: begin
               kind_ff <= one_kind_ff;
               byte_ff <= one_byte_ff;
               last_ff <= 1'b1;
            end
            SEL_ECHO_RAM: begin
               kind_ff <= KIND_ECHO;
               byte_ff <= ram_rdata;
            end
            SEL_CR: begin
               kind_ff <= KIND_ECHO;
               byte_ff <= CH_CR;
            end
            SEL_LF: begin
               kind_ff <= KIND_ECHO;
               byte_ff <= CH_LF;
            end
            SEL_LINE_RAM: begin
               kind_ff <= KIND_LINE;
               byte_ff <= ram_rdata;
            end
            SEL_END: begin
               kind_ff   <= KIND_END;
               byte_ff   <= '0;
               length_ff <= LEN_W'(len_ff);
               last_ff   <= 1'b1;
            end
            default: begin
               kind_ff <= KIND_END;
               byte_ff <= '0;
            end
         endcase
      end
   end

   // status back to the controller
   always_comb begin
      status.is_cr      = is_cr;
      status.has_result = !is_cr &&
                          (full || (!echo_at_line_end && (is_print || (is_bs && !empty))));
      status.echo_line  = echo_at_line_end && (len_ff != '0);
      status.copy_any   = (ncopy_ff != '0);
      status.echo_done  = (idx_next == len_ff);
      status.copy_done  = (idx_next == ncopy_ff);
      status.slot_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = kind_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_line_length = length_ff;
   assign rsp_run_last    = last_ff;

endmodule

// ===== sv/console_line_editor_top.sv =====
// -----------------------------------------------------------------------------
// console_line_editor_top
// Console line editor: edits a line from received bytes and replays it on
// carriage return.
// -----------------------------------------------------------------------------
// One received byte is handled at a time. A printable, backspace or overrun
// byte with a result beat is accepted, then its beat is loaded into the
// output register once the output slot is free; ignored bytes are only
// accepted. A carriage return walks the line store, which has a single read
// port with registered data, so each stored byte replayed, in line-end echo
// or in copy-out, passes a read state and then an emit state, which waits
// while the sink holds a waiting beat back.
// A new byte is taken while the last result beat still waits in the output
// register.
// -----------------------------------------------------------------------------
module console_line_editor_top (
   input  logic                                clock,
   input  logic                                reset,
   // received bytes
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [cle_pkg::BYTE_W-1:0]          req_rx_byte,
   // result beats
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cle_pkg::KIND_W-1:0]          rsp_result_kind,
   output logic [cle_pkg::BYTE_W-1:0]          rsp_out_byte,
   output logic [cle_pkg::LEN_W-1:0]           rsp_line_length,
   output logic                                rsp_run_last,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [cle_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [cle_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [cle_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   import cle_pkg::*;

   logic              echo_ff;
   logic [COPY_W-1:0] copy_limit_ff;
   logic              csr_wr;
   cmd_type           cmd;
   status_type        status;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_ff       <= 1'b0;
         copy_limit_ff <= COPY_RESET;
      end else if (csr_wr) begin
         if (csr_paddr[2] == REG_ECHO) begin
            echo_ff <= csr_pwdata[0];
         end else begin
            copy_limit_ff <= csr_pwdata[COPY_W-1:0];
         end
      end
   end

   // read back
   always_comb begin
      if (csr_paddr[2] == REG_COPY) begin
         csr_prdata = CSR_DATA_W'(copy_limit_ff);
      end else begin
         csr_prdata = CSR_DATA_W'(echo_ff);
      end
   end

   cle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   cle_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_rx_byte      (req_rx_byte),
      .echo_at_line_end (echo_ff),
      .copy_limit       (copy_limit_ff),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_line_length  (rsp_line_length),
      .rsp_run_last     (rsp_run_last)
   );

endmodule

// ===== sv/cle_checker.sv =====
// -----------------------------------------------------------------------------
// cle_checker
// Port-level checks on the console line editor, bound to the top level.
// -----------------------------------------------------------------------------
module cle_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic [cle_pkg::KIND_W-1:0]     rsp_result_kind,
   input logic [cle_pkg::BYTE_W-1:0]     rsp_out_byte,
   input logic [cle_pkg::LEN_W-1:0]      rsp_line_length,
   input logic                           rsp_run_last
);

   import cle_pkg::*;

   // a held result beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_kind) &&
      $stable(rsp_out_byte) && $stable(rsp_line_length) && $stable(rsp_run_last))
      else $error("result beat changed while stalled");

   // line end always closes the run
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_END) |-> rsp_run_last)
      else $error("line end beat without run_last");

   // overrun notice is a lone, empty beat
   a_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_OVERRUN) |-> rsp_run_last && (rsp_out_byte == '0))
      else $error("malformed overrun notice");

   // length only on line end
   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind != KIND_END) |-> (rsp_line_length == '0))
      else $error("line length on a non line-end beat");

   // line bytes are never the last beat of a run
   a_line_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_result_kind == KIND_LINE) |-> !rsp_run_last)
      else $error("line byte flagged as last");

endmodule

bind console_line_editor_top cle_checker u_cle_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_result_kind (rsp_result_kind),
   .rsp_out_byte    (rsp_out_byte),
   .rsp_line_length (rsp_line_length),
   .rsp_run_last    (rsp_run_last)
);

// ===== tb/testbench.sv =====
// -----------------------------------------------------------------------------
// testbench
// Self-checking bench for the console line editor: sends received bytes over
// the request channel, predicts every result beat from its own copy of the
// line store and registers, and checks each beat that leaves the block.
// -----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cle_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int SETTLE_TICKS = 12;
   localparam int TAIL_TICKS   = 60;
   localparam int MAX_REPORTS  = 100;

   localparam logic [CSR_ADDR_W-1:0] ADDR_ECHO = {REG_ECHO, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] ADDR_COPY = {REG_COPY, 2'b00};

   // one result beat as the editor should produce it
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [BYTE_W-1:0] data;
      logic [LEN_W-1:0]  len;
      logic              last;
   } editor_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   logic [BYTE_W-1:0]     req_rx_byte = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   logic [KIND_W-1:0]     rsp_result_kind;
   logic [BYTE_W-1:0]     rsp_out_byte;
   logic [LEN_W-1:0]      rsp_line_length;
   logic                  rsp_run_last;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // predicted editor state and register copies
   logic [BYTE_W-1:0] line_buf [LINE_LEN];
   int                fill_count = 0;
   logic              echo_mode  = 1'b0;
   logic [COPY_W-1:0] copy_lim   = COPY_RESET;

   editor_beat_type expected_beats [$];
   int              edit_items  = 0;
   int              error_count = 0;
   int              cycle_count = 0;

   // sender burst and receiver stall state
   int burst_left = 0;
   bit tx_idle_en = 1'b1;
   int rx_hold    = 0;
   int rx_mode    = 0;
   int rx_cycle   = 0;

   console_line_editor_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_kind (rsp_result_kind),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_line_length (rsp_line_length),
      .rsp_run_last    (rsp_run_last),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("ERROR @%0t: %s", $time, what);
   endtask

   function automatic editor_beat_type mk_beat(input logic [KIND_W-1:0] kind,
                                               input logic [BYTE_W-1:0] data,
                                               input logic [LEN_W-1:0]  len);
      editor_beat_type b;
      b.kind = kind;
      b.data = data;
      b.len  = len;
      b.last = 1'b0;
      return b;
   endfunction

   // work out the beats caused by one received byte and queue them
   function automatic void predict_edit(input logic [BYTE_W-1:0] ch);
      editor_beat_type run [$];
      editor_beat_type b;
      int              old_fill;
      int              line_len;
      int              n_copy;
      old_fill = fill_count;
      if (ch != CH_CR) begin
         if (fill_count < LINE_LEN) begin
            if (ch >= CH_FIRST_PRINT && ch <= CH_LAST_PRINT) begin
               line_buf[fill_count] = ch;
               fill_count++;
               if (!echo_mode) run.push_back(mk_beat(KIND_ECHO, ch, '0));
            end else if ((ch == CH_BS || ch == CH_DEL) && fill_count > 0) begin
               fill_count--;
               if (!echo_mode) run.push_back(mk_beat(KIND_ECHO, ch, '0));
            end
         end else begin
            // store full: notice and clear
            run.push_back(mk_beat(KIND_OVERRUN, '0, '0));
            fill_count = 0;
         end
      end else begin
         // line complete; a full store loses its last byte
         line_len = (fill_count >= LINE_LEN) ? LINE_LEN - 1 : fill_count;
         if (echo_mode)
            for (int i = 0; i < line_len; i++)
               run.push_back(mk_beat(KIND_ECHO, line_buf[i], '0));
         run.push_back(mk_beat(KIND_ECHO, CH_CR, '0));
         run.push_back(mk_beat(KIND_ECHO, CH_LF, '0));
         n_copy = (int'(copy_lim) < line_len) ? int'(copy_lim) : line_len;
         for (int i = 0; i < n_copy; i++)
            run.push_back(mk_beat(KIND_LINE, line_buf[i], '0));
         run.push_back(mk_beat(KIND_END, '0, LEN_W'(line_len)));
         fill_count = 0;
      end
      if (run.size() != 0 || fill_count != old_fill) edit_items++;
      for (int i = 0; i < run.size(); i++) begin
         b      = run[i];
         b.last = (i == run.size() - 1);
         expected_beats.push_back(b);
      end
   endfunction

   // result side: check each beat, then pick the next ready level
   always @(posedge clock) begin : rsp_side
      editor_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("unexpected beat kind %0d byte %02h len %0d last %0b",
                                      rsp_result_kind, rsp_out_byte, rsp_line_length,
                                      rsp_run_last));
         end else begin
            want = expected_beats.pop_front();
            if (rsp_result_kind !== want.kind || rsp_out_byte !== want.data ||
                rsp_line_length !== want.len || rsp_run_last !== want.last)
               report_mismatch($sformatf(
                  "beat kind %0d byte %02h len %0d last %0b, expected %0d %02h %0d %0b",
                  rsp_result_kind, rsp_out_byte, rsp_line_length, rsp_run_last,
                  want.kind, want.data, want.len, want.last));
         end
      end
      // stall pattern: mode 0 starts no new stalls, 1 now and then, 2 often
      rx_cycle++;
      if (rx_cycle % 97 == 0) rx_mode = $urandom_range(0, 2);
      if (rx_hold > 0) begin
         rsp_ready <= 1'b0;
         rx_hold--;
      end else if (rx_mode != 0 && $urandom_range(0, (rx_mode == 1) ? 7 : 1) == 0) begin
         rsp_ready <= 1'b0;
         rx_hold = $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // one received byte; valid stays high until the beat is taken
   task automatic send_byte(input logic [BYTE_W-1:0] ch);
      int gap;
      if (burst_left == 0) begin
         gap = tx_idle_en ? $urandom_range(0, 8) : 0;
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= ch;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_edit(ch);
   endtask

   // drop valid, let every expected beat arrive, then let the block settle
   task automatic wait_for_quiet();
      req_valid <= 1'b0;
      burst_left = 0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // register write followed straight away by a read back
   task automatic program_reg(input logic [CSR_ADDR_W-1:0] addr,
                              input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (addr == ADDR_ECHO) echo_mode = value[0];
      else                   copy_lim  = value[COPY_W-1:0];
      // read phase
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== value)
         report_mismatch($sformatf("register at %0d reads %08h, expected %08h",
                                   addr, csr_prdata, value));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // one line of random text with edits and noise, usually ended by CR
   task automatic send_random_line();
      int pick;
      int target;
      int typed;
      logic [BYTE_W-1:0] ch;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         // broken input: raw bytes, maybe no line end
         repeat ($urandom_range(1, 6)) send_byte(BYTE_W'($urandom_range(0, 255)));
         if ($urandom_range(0, 1) == 0) send_byte(CH_CR);
      end else begin
         if (pick < 70)      target = $urandom_range(0, 14);
         else if (pick < 86) target = $urandom_range(15, 16);
         else                target = $urandom_range(17, 20);
         typed = 0;
         while (typed < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               send_byte(($urandom_range(0, 1) == 0) ? CH_BS : CH_DEL);
            end else if (pick < 12) begin
               case ($urandom_range(0, 3))
                  0:       ch = BYTE_W'($urandom_range(0, 7));
                  1:       ch = BYTE_W'($urandom_range(9, 12));
                  2:       ch = BYTE_W'($urandom_range(14, 31));
                  default: ch = BYTE_W'($urandom_range(128, 255));
               endcase
               send_byte(ch);
            end else begin
               send_byte(BYTE_W'($urandom_range(CH_FIRST_PRINT, CH_LAST_PRINT)));
               typed++;
            end
         end
         send_byte(CH_CR);
      end
   endtask

   // ignored bytes, edits on an empty line, extremes and an empty line end
   task automatic test_basic_bytes();
      tx_idle_en = 1'b1;
      send_byte(CH_BS);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(CH_FIRST_PRINT);
      send_byte(CH_LAST_PRINT);
      send_byte(CH_DEL);
      send_byte(CH_BS);
      send_byte(CH_DEL);
      send_byte(CH_CR);
   endtask

   // full store at line end in line-end echo mode, copy limit below length
   task automatic test_full_line();
      wait_for_quiet();
      program_reg(ADDR_ECHO, CSR_DATA_W'(1));
      program_reg(ADDR_COPY, CSR_DATA_W'(5));
      repeat (LINE_LEN) send_byte(BYTE_W'($urandom_range(CH_FIRST_PRINT, CH_LAST_PRINT)));
      send_byte(CH_CR);
   endtask

   // random lines under one register setting
   task automatic test_random_phase(input logic echo, input int lim, input int n_items);
      int goal;
      wait_for_quiet();
      program_reg(ADDR_ECHO, CSR_DATA_W'(echo));
      program_reg(ADDR_COPY, CSR_DATA_W'(lim));
      tx_idle_en = ($urandom_range(0, 3) != 0);
      goal = edit_items + n_items;
      while (edit_items < goal) send_random_line();
   endtask

   initial begin
      for (int i = 0; i < LINE_LEN; i++) line_buf[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_bytes();
      test_full_line();
      test_random_phase(1'b0, 16, 60);
      test_random_phase(1'b1, 0, 60);
      test_random_phase(1'b0, 7, 70);
      test_random_phase(1'b1, 16, 70);
      test_random_phase(1'b0, 1, 50);
      test_random_phase(1'b1, $urandom_range(0, 16), 60);
      test_random_phase(1'b0, $urandom_range(0, 16), 60);

      wait_for_quiet();
      repeat (TAIL_TICKS) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
